// ===== design/imj_pkg.sv =====
// ----------------------------------------------------------------------------
// imj_pkg: shared types and constants for the IMU magnitude and jerk block
// Field widths, derived datapath widths, register indexes and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package imj_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int MAG_W       = 16;
  localparam int JERK_W      = 27;

  // Sum of three squares and its floor square root.
  localparam int SUM_W   = 2 * SAMPLE_BITS + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int PROD_W  = 2 * SAMPLE_BITS;

  // Jerk numerator magnitude: |delta| * 1000, and 1000 < 2**10.
  localparam int NUM_W   = SAMPLE_BITS + 10;

  localparam int SQ_PHASES  = 7;
  localparam int CALC_STEPS = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
  localparam int CNT_W      = $clog2(CALC_STEPS + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_EN = 2'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic             load;
    logic             square;
    logic             iterate;
    logic             publish;
    logic [CNT_W-1:0] idx;
  } imj_cmd_t;

  typedef struct packed {
    logic out_free;
  } imj_sts_t;

  function automatic logic [SAMPLE_BITS-1:0] abs_sample(input sample_t v);
    return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== design/imj_ctrl.sv =====
// ----------------------------------------------------------------------------
// imj_ctrl: sequencing controller
// Walks one request through capture, squaring, the shared iteration phase
// and publication into the output register.
// ----------------------------------------------------------------------------
module imj_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  imj_pkg::imj_sts_t sts,
  output imj_pkg::imj_cmd_t cmd
);
  import imj_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SQUARE  = 2'd1;
  localparam logic [1:0] S_CALC    = 2'd2;
  localparam logic [1:0] S_PUBLISH = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd.load    = 1'b0;
    cmd.square  = 1'b0;
    cmd.iterate = 1'b0;
    cmd.publish = 1'b0;
    cmd.idx     = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        if (cnt == CNT_W'(SQ_PHASES - 1)) begin
          cnt_next   = '0;
          state_next = S_CALC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CALC: begin
        cmd.iterate = 1'b1;
        if (cnt == CNT_W'(CALC_STEPS - 1)) begin
          state_next = S_PUBLISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PUBLISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> sts.out_free)
    else $error("result published while the output register is occupied");

  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("a second request was accepted while one is at work");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.square, cmd.iterate, cmd.publish}))
    else $error("more than one datapath command in a cycle");
`endif

endmodule

// ===== design/imj_datapath.sv =====
// ----------------------------------------------------------------------------
// imj_datapath: arithmetic and storage
// Holds the previous sample, a shared squaring multiplier, two bit-serial
// square roots, three restoring dividers and the output register.
// ----------------------------------------------------------------------------
module imj_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  imj_pkg::imj_cmd_t                      cmd,
  output imj_pkg::imj_sts_t                      sts,
  input  logic                                   cfg_valid,
  input  logic [imj_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic                                   cfg_data,
  input  logic [imj_pkg::TIME_W-1:0]             time_ms,
  input  imj_pkg::sample_t                       accel_x,
  input  imj_pkg::sample_t                       accel_y,
  input  imj_pkg::sample_t                       accel_z,
  input  imj_pkg::sample_t                       gyro_x,
  input  imj_pkg::sample_t                       gyro_y,
  input  imj_pkg::sample_t                       gyro_z,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [imj_pkg::TIME_W-1:0]             time_out,
  output logic [imj_pkg::MAG_W-1:0]              accel_magnitude,
  output logic [imj_pkg::MAG_W-1:0]              gyro_magnitude,
  output logic signed [imj_pkg::JERK_W-1:0]      jerk_x,
  output logic signed [imj_pkg::JERK_W-1:0]      jerk_y,
  output logic signed [imj_pkg::JERK_W-1:0]      jerk_z
);
  import imj_pkg::*;

  // Configuration.
  logic mag_en, jerk_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_en  <= 1'b1;
      jerk_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAG_EN:  mag_en  <= cfg_data;
        REG_JERK_EN: jerk_en <= cfg_data;
        default: ;
      endcase
    end
  end

  // Previous sample.
  sample_t           last_a [3];
  logic [TIME_W-1:0] last_time;
  logic              have_last;

  // Captured request.
  logic [TIME_W-1:0]      time_q;
  logic [SAMPLE_BITS-1:0] mag_s [6];
  logic [TIME_W-1:0]      dt;
  logic                   jerk_ok;
  logic                   neg [3];

  // Squares and roots.
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum  [2];
  logic [REM_W-1:0]  rem  [2];
  logic [ROOT_W-1:0] root [2];

  // Dividers: quotient shifts in where the numerator shifts out.
  logic [NUM_W-1:0]  quo  [3];
  logic [TIME_W-1:0] rmd  [3];

  sample_t accel_in [3];
  assign accel_in[0] = accel_x;
  assign accel_in[1] = accel_y;
  assign accel_in[2] = accel_z;

  logic signed [SAMPLE_BITS:0] delta     [3];
  logic [SAMPLE_BITS-1:0]      delta_mag [3];
  logic [NUM_W-1:0]            num       [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta[i] = $signed({accel_in[i][SAMPLE_BITS-1], accel_in[i]})
               - $signed({last_a[i][SAMPLE_BITS-1], last_a[i]});
      delta_mag[i] = delta[i][SAMPLE_BITS] ? SAMPLE_BITS'(~delta[i] + 1'b1)
                                           : SAMPLE_BITS'(delta[i]);
      // Times 1000 as 1024 - 16 - 8.
      num[i] = (NUM_W'(delta_mag[i]) << 10) - (NUM_W'(delta_mag[i]) << 4)
             - (NUM_W'(delta_mag[i]) << 3);
    end
  end

  logic [SAMPLE_BITS-1:0] sq_op;

  always_comb begin
    case (cmd.idx[2:0])
      3'd1:    sq_op = mag_s[1];
      3'd2:    sq_op = mag_s[2];
      3'd3:    sq_op = mag_s[3];
      3'd4:    sq_op = mag_s[4];
      3'd5:    sq_op = mag_s[5];
      default: sq_op = mag_s[0];
    endcase
  end

  logic [REM_W-1:0] rem_sh [2];
  logic [REM_W-1:0] trial  [2];
  logic             rt_ge  [2];
  logic [TIME_W:0]  rmd_sh [3];
  logic             dv_ge  [3];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rem_sh[k] = {rem[k][REM_W-3:0], sum[k][SUM_W-1:SUM_W-2]};
      trial[k]  = {root[k], 2'b01};
      rt_ge[k]  = (rem_sh[k] >= trial[k]);
    end
    for (int i = 0; i < 3; i++) begin
      rmd_sh[i] = {rmd[i], quo[i][NUM_W-1]};
      dv_ge[i]  = (rmd_sh[i] >= {1'b0, dt});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      last_time <= '0;
      for (int i = 0; i < 3; i++) last_a[i] <= '0;
    end else if (cmd.load) begin
      have_last <= 1'b1;
      last_time <= time_ms;
      for (int i = 0; i < 3; i++) last_a[i] <= accel_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_q   <= time_ms;
      mag_s[0] <= abs_sample(accel_x);
      mag_s[1] <= abs_sample(accel_y);
      mag_s[2] <= abs_sample(accel_z);
      mag_s[3] <= abs_sample(gyro_x);
      mag_s[4] <= abs_sample(gyro_y);
      mag_s[5] <= abs_sample(gyro_z);
      dt       <= time_ms - last_time;
      jerk_ok  <= have_last && (time_ms > last_time);
      for (int k = 0; k < 2; k++) begin
        sum[k]  <= '0;
        rem[k]  <= '0;
        root[k] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        neg[i] <= delta[i][SAMPLE_BITS];
        quo[i] <= num[i];
        rmd[i] <= '0;
      end
    end
    if (cmd.square) begin
      prod <= sq_op * sq_op;
      // The product of phase n lands in the sum during phase n + 1.
      if (cmd.idx >= CNT_W'(1) && cmd.idx <= CNT_W'(3)) begin
        sum[0] <= sum[0] + SUM_W'(prod);
      end else if (cmd.idx >= CNT_W'(4)) begin
        sum[1] <= sum[1] + SUM_W'(prod);
      end
    end
    if (cmd.iterate) begin
      if (cmd.idx < CNT_W'(ROOT_W)) begin
        for (int k = 0; k < 2; k++) begin
          sum[k]  <= sum[k] << 2;
          rem[k]  <= rt_ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
          root[k] <= {root[k][ROOT_W-2:0], rt_ge[k]};
        end
      end
      if (cmd.idx < CNT_W'(NUM_W)) begin
        for (int i = 0; i < 3; i++) begin
          rmd[i] <= dv_ge[i] ? TIME_W'(rmd_sh[i] - {1'b0, dt}) : TIME_W'(rmd_sh[i]);
          quo[i] <= {quo[i][NUM_W-2:0], dv_ge[i]};
        end
      end
    end
  end

  // Output register.
  logic signed [NUM_W:0]  jv [3];
  logic signed [JERK_W-1:0] jr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      jv[i] = neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      jr[i] = (jerk_en && jerk_ok) ? JERK_W'(jv[i]) : '0;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      time_out        <= time_q;
      accel_magnitude <= mag_en ? MAG_W'(root[0]) : '0;
      gyro_magnitude  <= mag_en ? MAG_W'(root[1]) : '0;
      jerk_x          <= jr[0];
      jerk_y          <= jr[1];
      jerk_z          <= jr[2];
    end
  end

endmodule

// ===== design/imu_magnitude_jerk_features.sv =====
// ----------------------------------------------------------------------------
// imu_magnitude_jerk_features: accel and gyro magnitudes plus per-axis jerk
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage notes.
// A request on the input channel carries one six-axis sample and its
// millisecond timestamp; it is taken at a clock edge where in_valid is high
// and in_stall is low. Each request yields exactly one result on the output
// channel, taken where out_valid is high and out_stall is low.
// The request passes these steps: the sample is captured at the accepting
// edge, then comes a squaring phase on the single shared multiplier, then
// an iteration phase in which the two square roots (one bit per cycle) and
// the three restoring dividers (one quotient bit per cycle) run side by
// side, and last a publish step. The divider length, SAMPLE_BITS + 10
// quotient bits, sets the length of the iteration phase. in_stall stays
// high until the result is published, so no new request is taken before
// the last one is through. The output register frees the input side: the
// next request is taken while a finished result still waits.
// If the receiver stalls, the result holds in the output register; a second
// finished result then waits in the publish step and in_stall stays high.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; it should be written only while no request is in flight.
// Synchronous reset enables both features and forgets the previous sample,
// so the first jerk after reset is zero.
// ----------------------------------------------------------------------------
module imu_magnitude_jerk_features (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [imj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [imj_pkg::TIME_W-1:0]        time_ms,
  input  imj_pkg::sample_t                  accel_x,
  input  imj_pkg::sample_t                  accel_y,
  input  imj_pkg::sample_t                  accel_z,
  input  imj_pkg::sample_t                  gyro_x,
  input  imj_pkg::sample_t                  gyro_y,
  input  imj_pkg::sample_t                  gyro_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imj_pkg::TIME_W-1:0]        time_out,
  output logic [imj_pkg::MAG_W-1:0]         accel_magnitude,
  output logic [imj_pkg::MAG_W-1:0]         gyro_magnitude,
  output logic signed [imj_pkg::JERK_W-1:0] jerk_x,
  output logic signed [imj_pkg::JERK_W-1:0] jerk_y,
  output logic signed [imj_pkg::JERK_W-1:0] jerk_z
);
  import imj_pkg::*;

  imj_cmd_t cmd;
  imj_sts_t sts;

  // Register writes are never held off, even during work, so the port is always open.
  assign cfg_ready = 1'b1;

  imj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imj_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .time_ms         (time_ms),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .gyro_x          (gyro_x),
    .gyro_y          (gyro_y),
    .gyro_z          (gyro_z),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .time_out        (time_out),
    .accel_magnitude (accel_magnitude),
    .gyro_magnitude  (gyro_magnitude),
    .jerk_x          (jerk_x),
    .jerk_y          (jerk_y),
    .jerk_z          (jerk_z)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for imu_magnitude_jerk_features
// Drives six-axis samples through the valid/stall input channel, predicts the
// magnitude and jerk of each one, and compares every result that leaves the
// output channel with the prediction, under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import imj_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 8_000_000;
  localparam int PHASE_ITEMS  = 160;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    sample_t           ax, ay, az;
    sample_t           gx, gy, gz;
  } imu_sample_t;

  typedef struct packed {
    logic [TIME_W-1:0]        t;
    logic [MAG_W-1:0]         amag;
    logic [MAG_W-1:0]         gmag;
    logic signed [JERK_W-1:0] jx, jy, jz;
  } feature_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic                     cfg_data  = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [TIME_W-1:0]        time_ms   = '0;
  sample_t                  accel_x   = '0;
  sample_t                  accel_y   = '0;
  sample_t                  accel_z   = '0;
  sample_t                  gyro_x    = '0;
  sample_t                  gyro_y    = '0;
  sample_t                  gyro_z    = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [TIME_W-1:0]        time_out;
  logic [MAG_W-1:0]         accel_magnitude;
  logic [MAG_W-1:0]         gyro_magnitude;
  logic signed [JERK_W-1:0] jerk_x;
  logic signed [JERK_W-1:0] jerk_y;
  logic signed [JERK_W-1:0] jerk_z;

  imu_magnitude_jerk_features i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .time_ms         (time_ms),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .gyro_x          (gyro_x),
    .gyro_y          (gyro_y),
    .gyro_z          (gyro_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .time_out        (time_out),
    .accel_magnitude (accel_magnitude),
    .gyro_magnitude  (gyro_magnitude),
    .jerk_x          (jerk_x),
    .jerk_y          (jerk_y),
    .jerk_z          (jerk_z)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the two enables and of the previous
  // sample, updated at the same edges at which the block takes a register
  // write or a request.
  // --------------------------------------------------------------------------
  logic              mag_en_model;
  logic              jerk_en_model;
  logic              have_prev;
  logic [TIME_W-1:0] prev_time;
  sample_t           prev_ax, prev_ay, prev_az;

  feature_t expected_features[$];
  int       mismatch_count = 0;

  // Floor square root of the summed squares, found by building the root one
  // bit at a time from the top over 17 bits; the largest root fits in 16.
  function automatic logic [MAG_W-1:0] vector_length(sample_t u, sample_t v, sample_t w);
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] cand;
    sum  = 64'(longint'(u) * longint'(u) + longint'(v) * longint'(v)
               + longint'(w) * longint'(w));
    root = '0;
    for (int k = 16; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (cand * cand <= sum) root = cand;
    end
    return root[MAG_W-1:0];
  endfunction

  // Signed 64-bit division truncates toward zero, which is what jerk needs.
  function automatic logic signed [JERK_W-1:0] axis_jerk(sample_t now_v, sample_t old_v,
                                                         logic [TIME_W-1:0] dt);
    longint num;
    longint q;
    num = (longint'(now_v) - longint'(old_v)) * 1000;
    q   = num / longint'({32'd0, dt});
    return q[JERK_W-1:0];
  endfunction

  function automatic feature_t predict_features(imu_sample_t s);
    feature_t          f;
    logic [TIME_W-1:0] dt;
    f = '0;
    f.t = s.t;
    if (mag_en_model) begin
      f.amag = vector_length(s.ax, s.ay, s.az);
      f.gmag = vector_length(s.gx, s.gy, s.gz);
    end
    // No jerk on the first sample or when time stands still or goes back.
    if (jerk_en_model && have_prev && s.t > prev_time) begin
      dt   = s.t - prev_time;
      f.jx = axis_jerk(s.ax, prev_ax, dt);
      f.jy = axis_jerk(s.ay, prev_ay, dt);
      f.jz = axis_jerk(s.az, prev_az, dt);
    end
    return f;
  endfunction

  // Watches both request channels; inputs are sampled at the edge itself, so
  // the values seen here are the ones the block takes.
  always @(posedge clk) begin : request_monitor
    imu_sample_t s;
    if (rst) begin
      mag_en_model  <= 1'b1;
      jerk_en_model <= 1'b1;
      have_prev     <= 1'b0;
      prev_time     <= '0;
      prev_ax       <= '0;
      prev_ay       <= '0;
      prev_az       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAG_EN:  mag_en_model  <= cfg_data;
          REG_JERK_EN: jerk_en_model <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        s = {time_ms, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z};
        expected_features.push_back(predict_features(s));
        // The history moves on even while the features are switched off.
        prev_time <= s.t;
        prev_ax   <= s.ax;
        prev_ay   <= s.ay;
        prev_az   <= s.az;
        have_prev <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    feature_t want;
    feature_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {time_out, accel_magnitude, gyro_magnitude, jerk_x, jerk_y, jerk_z};
      if (expected_features.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual time_out %0h",
                 $time, time_out);
        mismatch_count++;
      end else begin
        want = expected_features.pop_front();
        compare_field("time_out", want.t, got.t);
        compare_field("accel_magnitude", want.amag, got.amag);
        compare_field("gyro_magnitude", want.gmag, got.gmag);
        compare_field("jerk_x", want.jx, got.jx);
        compare_field("jerk_y", want.jy, got.jy);
        compare_field("jerk_z", want.jz, got.jz);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: out_stall holds each level for a random number of cycles. The
  // test in progress chooses how often and how long it stalls, or switches
  // stalling off for a clean stretch.
  // --------------------------------------------------------------------------
  bit stall_enable  = 1'b0;
  int stall_percent = 0;
  int stall_span    = 0;
  int stall_hold    = 0;

  always @(posedge clk) begin : stall_pattern
    if (!stall_enable) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold == 0) begin
      out_stall  <= ($urandom_range(0, 99) < stall_percent);
      stall_hold <= $urandom_range(0, stall_span);
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length; between bursts valid
  // drops for a random gap, long enough at times to outlast the block's
  // whole computation so that gaps land on every phase of it.
  // --------------------------------------------------------------------------
  bit          sender_gaps = 1'b0;
  int          gap_max     = 1;
  int          burst_left  = 0;
  imu_sample_t last_sent   = '0;

  // Called at a rising edge; returns at the accepting edge or after a gap.
  task automatic send_sample(imu_sample_t s);
    in_valid <= 1'b1;
    time_ms  <= s.t;
    accel_x  <= s.ax;
    accel_y  <= s.ay;
    accel_z  <= s.az;
    gyro_x   <= s.gx;
    gyro_y   <= s.gy;
    gyro_z   <= s.gz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_sent = s;
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Waits until every prediction has been matched; registers may then change.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_features.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic imu_sample_t make_sample(logic [TIME_W-1:0] t,
                                              sample_t ax, sample_t ay, sample_t az,
                                              sample_t gx, sample_t gy, sample_t gz);
    return {t, ax, ay, az, gx, gy, gz};
  endfunction

  // One axis: often fully random, often a small step from the last value as
  // a real sensor would move, and sometimes an end of the range.
  function automatic sample_t random_axis(sample_t prev);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45) return sample_t'($urandom);
    if (r < 85) begin
      v = int'(prev) + int'($urandom_range(0, 1000)) - 500;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return sample_t'(v);
    end
    case ($urandom_range(0, 3))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'(-1);
      default: return sample_t'(0);
    endcase
  endfunction

  // Timestamps mostly move forward by 1 to 50 milliseconds; now and then they
  // repeat, step back, jump anywhere, or sit just below the wrap point.
  function automatic imu_sample_t next_random_sample();
    imu_sample_t s;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 80)      s.t = last_sent.t + $urandom_range(1, 50);
    else if (r < 87) s.t = last_sent.t;
    else if (r < 93) s.t = last_sent.t - $urandom_range(1, 2000);
    else if (r < 96) s.t = 32'hFFFF_FFFF - $urandom_range(0, 20);
    else             s.t = $urandom;
    s.ax = random_axis(last_sent.ax);
    s.ay = random_axis(last_sent.ay);
    s.az = random_axis(last_sent.az);
    s.gx = random_axis(last_sent.gx);
    s.gy = random_axis(last_sent.gy);
    s.gz = random_axis(last_sent.gz);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Right after reset both features are on and there is no history, so the
  // first jerk is zero. Then the largest possible swings with dt of one
  // millisecond, the largest magnitudes, a zero vector and a huge dt.
  task automatic test_reset_and_extremes();
    send_sample(make_sample(32'd100, -32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32'd101, 32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(32'd102, -32768, 32767, 0, 0, -32768, 32767));
    send_sample(make_sample(32'd103, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(32'hFFFF_FFFF, 32767, -32768, -1, 1, -1, 32767));
    drain_pipeline();
  endtask

  // Jerk is zero when the timestamp repeats, goes back or wraps, and a
  // negative quotient is truncated toward zero rather than down.
  task automatic test_time_ordering();
    send_sample(make_sample(32'd2000, 0, 0, 0, 3, 4, 0));
    send_sample(make_sample(32'd2000, 100, -100, 100, 0, 0, 0));
    send_sample(make_sample(32'd1999, -5, 5, -5, 1, 1, 1));
    send_sample(make_sample(32'd2003, 7, -7, 9, 2, 2, 1));
    send_sample(make_sample(32'd2006, -3, 3, 0, 0, 0, 0));
    send_sample(make_sample(32'hFFFF_FFFF, 1, 2, 3, 0, 0, 0));
    send_sample(make_sample(32'd0, 2, 3, 4, 0, 0, 0));
    send_sample(make_sample(32'd1, 3, 4, 5, 0, 0, 0));
    drain_pipeline();
  endtask

  // Each enable on its own, the spare indexes, and the history kept while
  // jerk is off: the first jerk after enabling again is taken against the
  // sample seen while it was disabled.
  task automatic test_feature_enables();
    write_register(REG_MAG_EN, 1'b0);
    send_sample(make_sample(32'd10, 1000, -2000, 3000, -4000, 5000, -6000));
    send_sample(make_sample(32'd20, -1000, 2000, -3000, 4000, -5000, 6000));
    drain_pipeline();
    write_register(REG_MAG_EN, 1'b1);
    write_register(REG_JERK_EN, 1'b0);
    send_sample(make_sample(32'd30, 500, 500, 500, 7, 7, 7));
    send_sample(make_sample(32'd40, -500, 1500, 250, 9, 9, 9));
    drain_pipeline();
    write_register(REG_JERK_EN, 1'b1);
    write_register(REG_SPARE_2, 1'b0);
    write_register(REG_SPARE_3, 1'b0);
    send_sample(make_sample(32'd47, 1200, -800, 250, 11, -11, 11));
    send_sample(make_sample(32'd60, 1201, -801, 251, 12, -12, 12));
    drain_pipeline();
    write_register(REG_MAG_EN, 1'b0);
    write_register(REG_JERK_EN, 1'b0);
    write_register(REG_SPARE_2, 1'b1);
    write_register(REG_SPARE_3, 1'b1);
    send_sample(make_sample(32'd61, 40, 40, 40, 40, 40, 40));
    drain_pipeline();
  endtask

  // Random samples in phases, each with one of four register settings and its
  // own mix of sender gaps and receiver stalls; some phases run with no
  // idling at all on one side or both.
  task automatic test_random_stream();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          write_register(REG_MAG_EN, 1'b1);
          write_register(REG_JERK_EN, 1'b1);
        end
        1: begin
          write_register(REG_MAG_EN, 1'b0);
          write_register(REG_JERK_EN, 1'b1);
        end
        2: begin
          write_register(REG_MAG_EN, 1'b1);
          write_register(REG_JERK_EN, 1'b0);
        end
        default: begin
          write_register(REG_MAG_EN, 1'b0);
          write_register(REG_JERK_EN, 1'b0);
          write_register(REG_SPARE_2, p[2]);
          write_register(REG_SPARE_3, ~p[2]);
        end
      endcase
      stall_enable  = (p != 0) && (p != 4);
      stall_percent = 20 + 8 * p;
      stall_span    = 5 * p;
      sender_gaps   = (p != 0) && (p != 5);
      gap_max       = 10 + 6 * p;
      burst_left    = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(next_random_sample());
      drain_pipeline();
    end
    stall_enable = 1'b0;
    sender_gaps  = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_and_extremes();
    test_time_ordering();
    test_feature_enables();
    test_random_stream();
    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_features.size() == 0) begin
      $display("imu_magnitude_jerk_features verification clean");
    end else begin
      $display("imu_magnitude_jerk_features verification failed");
    end
    $finish;
  end

  // A hang anywhere, including a result that never comes, ends here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("imu_magnitude_jerk_features verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/imj_pkg.sv
design/imj_ctrl.sv
design/imj_datapath.sv
design/imu_magnitude_jerk_features.sv
test/testbench.sv
